@@ design/sha_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } item_t;

  localparam int unsigned QueueDepth = 4;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

@@ design/sha_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sha_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sha_pkg::item_t  in_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sha_pkg::item_t       out_item
);
  localparam int unsigned AW = $clog2(sha_pkg::QueueDepth);

  sha_pkg::item_t mem_r [sha_pkg::QueueDepth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          push, pop;

  assign in_ready  = (cnt_r != (AW+1)'(sha_pkg::QueueDepth));
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

@@ design/sha_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sha_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire sha_pkg::item_t  item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [31:0]          out_digest_word,
  output logic [2:0]           out_word_index,
  output logic                 out_last_word
);
  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_ROUND, S_ADD, S_LEN, S_EMIT
  } state_t;

  state_t        state_r;
  logic [31:0]   w_r [16];
  logic [31:0]   v_r [8];
  logic [31:0]   h_r [8];
  logic [60:0]   cnt_r;
  logic [5:0]    t_r;
  logic          fin_r;
  logic          two_r;
  logic [2:0]    idx_r;

  logic [5:0]  pos;
  logic [31:0] s0, s1, wn, wt, t1, t2;
  logic [31:0] a, b, c, e, f, g;
  logic [31:0] pw [16];
  logic [31:0] len_hi, len_lo;

  assign pos = cnt_r[5:0];
  assign a = v_r[0]; assign b = v_r[1]; assign c = v_r[2];
  assign e = v_r[4]; assign f = v_r[5]; assign g = v_r[6];
  assign len_hi = cnt_r[60:29];
  assign len_lo = {cnt_r[28:0], 3'b000};

  always_comb begin
    s0 = sha_pkg::rotr(w_r[1], 7) ^ sha_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = sha_pkg::rotr(w_r[14], 17) ^ sha_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
    wt = w_r[0];
    t1 = v_r[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
       + ((e & f) ^ (~e & g)) + sha_pkg::RoundK[t_r] + wt;
    t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
       + ((a & b) ^ (a & c) ^ (b & c));
  end

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      for (int k = 0; k < 4; k++) begin
        if (6'(4 * j + k) == pos) pw[j][8 * (3 - k) +: 8] = 8'h80;
        else if (6'(4 * j + k) > pos) pw[j][8 * (3 - k) +: 8] = 8'h00;
        else pw[j][8 * (3 - k) +: 8] = w_r[j][8 * (3 - k) +: 8];
      end
    end
  end

  assign item_ready      = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_EMIT);
  assign out_digest_word = h_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      t_r <= '0;
      fin_r <= 1'b0;
      two_r <= 1'b0;
      idx_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::InitHash[i];
    end else begin
      case (state_r)
        S_IDLE: begin
          if (item_valid) begin
            fin_r <= item.last;
            if (item.has_byte) begin
              w_r[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= item.data;
              cnt_r <= cnt_r + 61'd1;
              if (pos == 6'd63) begin
                for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
                t_r <= '0;
                state_r <= S_ROUND;
              end else if (item.last) begin
                state_r <= S_PAD;
              end
            end else if (item.last) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          for (int i = 0; i < 14; i++) w_r[i] <= pw[i];
          fin_r <= 1'b0;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          t_r <= '0;
          state_r <= S_ROUND;
          if (pos >= 6'd56) begin
            w_r[14] <= pw[14];
            w_r[15] <= pw[15];
            two_r <= 1'b1;
          end else begin
            w_r[14] <= len_hi;
            w_r[15] <= len_lo;
            two_r <= 1'b0;
            idx_r <= 3'd1;
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wn;
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          t_r <= t_r + 6'd1;
          if (t_r == 6'd63) state_r <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          if (fin_r) begin
            state_r <= S_PAD;
          end else if (two_r) begin
            two_r <= 1'b0;
            state_r <= S_LEN;
          end else if (idx_r == 3'd1) begin
            idx_r <= '0;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_LEN: begin
          for (int i = 0; i < 14; i++) w_r[i] <= '0;
          w_r[14] <= len_hi;
          w_r[15] <= len_lo;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          t_r <= '0;
          idx_r <= 3'd1;
          state_r <= S_ROUND;
        end
        S_EMIT: begin
          if (out_ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::InitHash[i];
              cnt_r <= '0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ design/sha256_message_hasher_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A byte that does not complete a block is stored and leaves the core idle; a block-completing byte
// holds the core for the rounds and hash update, run by the one-round-per-cycle loop.
// End of message adds one or two padding compressions, then eight digest transfers.
// A four-entry queue takes bytes while the core is busy.
// Synchronous active-low reset restores the initial hash values and a zero byte count.
module sha256_message_hasher_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_message_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  sha_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;

  assign in_item.data = in_message_byte;
  assign in_item.has_byte = in_has_byte;
  assign in_item.last = in_end_of_message;

  sha_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  sha_core u_core (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );
endmodule
`default_nettype wire
